[hw/rtl/alarm_match_with_auto_snooze_top_assert.svh]
// assertion macros for the alarm matcher checker
// used by the checker file only; needs no package
`ifndef ALARM_MATCH_WITH_AUTO_SNOOZE_TOP_ASSERT_SVH
`define ALARM_MATCH_WITH_AUTO_SNOOZE_TOP_ASSERT_SVH

// same-cycle implication under synchronous active-low reset
`define AMAS_ASSERT_IMPLY(label, clk, rst_n, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |-> (cons)) \
    else $error("alarm matcher assertion failed");

// next-cycle implication under synchronous active-low reset
`define AMAS_ASSERT_NEXT(label, clk, rst_n, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |=> (cons)) \
    else $error("alarm matcher assertion failed");

`endif

[hw/rtl/amas_pkg.sv]
// shared types and constants for the alarm matcher with auto snooze
// no dependencies
`timescale 1ns / 1ps

package amas_pkg;

  localparam int MinuteW = 11;
  localparam int SecondW = 6;
  localparam int RingCntW = 4;
  localparam int TallyW = 8;
  localparam int CfgIdxW = 1;

  localparam logic [MinuteW-1:0] MINUTES_PER_DAY = 11'd1440;
  localparam logic [MinuteW-1:0] NO_MINUTE = 11'h7FF;
  localparam logic [SecondW-1:0] NO_SECOND = 6'h3F;
  localparam logic [MinuteW-1:0] MINUTES_PER_HOUR = 11'd60;
  localparam logic [RingCntW-1:0] RING_SECONDS = 4'd10;

  // configuration register indexes
  localparam logic [CfgIdxW-1:0] CFG_FIRST_ALARM = 1'b0;
  localparam logic [CfgIdxW-1:0] CFG_SECOND_ALARM = 1'b1;

  typedef struct packed {
    logic ringing;
    logic acknowledged;
    logic screen_drawn;
    logic [MinuteW-1:0] last_fired_minute;
    logic [MinuteW-1:0] snooze_minute;
    logic snooze_pending;
    logic [TallyW-1:0] snooze_tally;
    logic [RingCntW-1:0] ring_seconds;
    logic [SecondW-1:0] previous_second;
  } amas_state_t;

  typedef struct packed {
    logic buzzer_on;
    logic alarm_ringing;
    logic [MinuteW-1:0] ringing_minute;
    logic show_screen;
    logic auto_snoozed;
    logic dismissed;
    logic [TallyW-1:0] snoozes_so_far;
  } amas_result_t;

endpackage

[hw/rtl/amas_if.sv]
// valid/ready channel interfaces for clock samples and alarm results
// no dependencies
`timescale 1ns / 1ps

interface amas_in_if;
  logic valid;
  logic ready;
  logic [4:0] clock_hour;
  logic [5:0] clock_minute;
  logic [5:0] clock_second;
  logic dismiss_pressed;

  modport source (output valid, output clock_hour, output clock_minute,
                  output clock_second, output dismiss_pressed, input ready);
  modport sink (input valid, input clock_hour, input clock_minute,
                input clock_second, input dismiss_pressed, output ready);
endinterface

interface amas_out_if;
  logic valid;
  logic ready;
  logic buzzer_on;
  logic alarm_ringing;
  logic [10:0] ringing_minute;
  logic show_screen;
  logic auto_snoozed;
  logic dismissed;
  logic [7:0] snoozes_so_far;

  modport source (output valid, output buzzer_on, output alarm_ringing,
                  output ringing_minute, output show_screen, output auto_snoozed,
                  output dismissed, output snoozes_so_far, input ready);
  modport sink (input valid, input buzzer_on, input alarm_ringing,
                input ringing_minute, input show_screen, input auto_snoozed,
                input dismissed, input snoozes_so_far, output ready);
endinterface

[hw/rtl/amas_step.sv]
// next-state and result logic for one clock sample of the alarm matcher
// depends on amas_pkg
`timescale 1ns / 1ps

module amas_step import amas_pkg::*; (
  input  amas_state_t        state_cur,
  input  logic [MinuteW-1:0] first_alarm,
  input  logic [MinuteW-1:0] second_alarm,
  input  logic [MinuteW-1:0] now_minute,
  input  logic [SecondW-1:0] now_second,
  input  logic               pressed,
  output amas_state_t        state_nxt,
  output amas_result_t       result
);

  logic [MinuteW-1:0] now_inc;
  logic [MinuteW-1:0] snooze_wrap;

  // next minute, wrapped once at end of day
  assign now_inc = now_minute + 11'd1;
  assign snooze_wrap = (now_inc >= MINUTES_PER_DAY) ? (now_inc - MINUTES_PER_DAY) : now_inc;

  always_comb begin
    logic alarm_hit;
    logic snooze_hit;
    amas_state_t s;
    s = state_cur;
    result = '0;

    if (now_minute != s.last_fired_minute) begin
      s.acknowledged = 1'b0;
    end

    alarm_hit = (now_minute == first_alarm) || (now_minute == second_alarm);
    snooze_hit = s.snooze_pending && (now_minute == s.snooze_minute) && (now_second == '0);
    if (!s.ringing && !s.acknowledged && (alarm_hit || snooze_hit)) begin
      s.ringing = 1'b1;
      s.screen_drawn = 1'b0;
      s.snooze_pending = 1'b0;
      s.last_fired_minute = now_minute;
    end

    if (s.ringing) begin
      if (now_minute == first_alarm) begin
        result.ringing_minute = first_alarm;
      end else if (now_minute == second_alarm) begin
        result.ringing_minute = second_alarm;
      end else begin
        result.ringing_minute = s.snooze_minute;
      end

      if (!s.screen_drawn) begin
        s.screen_drawn = 1'b1;
        result.show_screen = 1'b1;
      end
      if (s.previous_second != now_second) begin
        s.previous_second = now_second;
        s.ring_seconds = s.ring_seconds + 4'd1;
      end

      // auto snooze wins over the switch
      if (s.ring_seconds >= RING_SECONDS) begin
        s.ringing = 1'b0;
        s.ring_seconds = '0;
        s.snooze_minute = snooze_wrap;
        s.snooze_pending = 1'b1;
        s.snooze_tally = s.snooze_tally + 8'd1;
        s.acknowledged = 1'b1;
        result.auto_snoozed = 1'b1;
      end else if (pressed) begin
        s.ringing = 1'b0;
        s.screen_drawn = 1'b0;
        s.acknowledged = 1'b1;
        result.dismissed = 1'b1;
      end
    end

    result.buzzer_on = s.ringing;
    result.alarm_ringing = s.ringing;
    result.snoozes_so_far = s.snooze_tally;
    state_nxt = s;
  end

endmodule

[hw/rtl/alarm_match_with_auto_snooze_top.sv]
// top level of the alarm matcher with auto snooze
// depends on amas_pkg, amas_if (amas_in_if, amas_out_if) and amas_step
`timescale 1ns / 1ps
//
//  channel   direction  carries                                      handshake
//  in_chan   sink       hour, minute, second, dismiss switch         valid/ready
//  out_chan  source     buzzer, ringing flag, shown minute, pulses   valid/ready
//  cfg_*     write      alarm minute registers, index 0 and 1        cfg_we only
//
// one request per cycle sustained while the result is taken; after accept,
// stage one registers minute of day (hour*60+minute), stage two runs the
// alarm state update and registers the result
// rst_n is synchronous and clears all alarm state and both valid flags
// a stalled result holds stage two; stage one still fills, so input stalls
// only when both stages are full and the result is not taken

module alarm_match_with_auto_snooze_top import amas_pkg::*; (
  input  logic               clk,
  input  logic               rst_n,
  amas_in_if.sink            in_chan,
  amas_out_if.source         out_chan,
  input  logic               cfg_we,
  input  logic [CfgIdxW-1:0] cfg_index,
  input  logic [MinuteW-1:0] cfg_wdata
);

  // configuration registers
  logic [MinuteW-1:0] first_alarm_r;
  logic [MinuteW-1:0] second_alarm_r;

  // stage one: registered sample
  logic               s1_valid_r;
  logic [MinuteW-1:0] s1_minute_r;
  logic [SecondW-1:0] s1_second_r;
  logic               s1_pressed_r;
  logic [MinuteW-1:0] s1_minute_nxt;

  // stage two: registered result
  logic               out_valid_r;
  amas_result_t       result_r;
  amas_result_t       result_nxt;

  // alarm state
  amas_state_t        state_r;
  amas_state_t        state_nxt;

  logic s1_go;
  logic in_take;

  // stage one moves on whenever the result slot is free or being emptied
  assign s1_go = s1_valid_r && (!out_valid_r || out_chan.ready);
  assign in_chan.ready = !s1_valid_r || s1_go;
  assign in_take = in_chan.valid && in_chan.ready;

  // minute of day, at most 31*60+63 so it fits eleven bits
  assign s1_minute_nxt = (MinuteW'(in_chan.clock_hour) * MINUTES_PER_HOUR)
                         + MinuteW'(in_chan.clock_minute);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      first_alarm_r <= '0;
      second_alarm_r <= '0;
    end else if (cfg_we) begin
      case (cfg_index)
        CFG_FIRST_ALARM: first_alarm_r <= cfg_wdata;
        CFG_SECOND_ALARM: second_alarm_r <= cfg_wdata;
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_valid_r <= 1'b0;
    end else if (in_take) begin
      s1_valid_r <= 1'b1;
    end else if (s1_go) begin
      s1_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (in_take) begin
      s1_minute_r <= s1_minute_nxt;
      s1_second_r <= in_chan.clock_second;
      s1_pressed_r <= in_chan.dismiss_pressed;
    end
  end

  amas_step u_step (
    .state_cur    (state_r),
    .first_alarm  (first_alarm_r),
    .second_alarm (second_alarm_r),
    .now_minute   (s1_minute_r),
    .now_second   (s1_second_r),
    .pressed      (s1_pressed_r),
    .state_nxt    (state_nxt),
    .result       (result_nxt)
  );

  // state advances once per request, as it enters stage two
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r.ringing <= 1'b0;
      state_r.acknowledged <= 1'b0;
      state_r.screen_drawn <= 1'b0;
      state_r.last_fired_minute <= NO_MINUTE;
      state_r.snooze_minute <= NO_MINUTE;
      state_r.snooze_pending <= 1'b0;
      state_r.snooze_tally <= '0;
      state_r.ring_seconds <= '0;
      state_r.previous_second <= NO_SECOND;
    end else if (s1_go) begin
      state_r <= state_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (s1_go) begin
      out_valid_r <= 1'b1;
    end else if (out_chan.ready) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (s1_go) begin
      result_r <= result_nxt;
    end
  end

  assign out_chan.valid = out_valid_r;
  assign out_chan.buzzer_on = result_r.buzzer_on;
  assign out_chan.alarm_ringing = result_r.alarm_ringing;
  assign out_chan.ringing_minute = result_r.ringing_minute;
  assign out_chan.show_screen = result_r.show_screen;
  assign out_chan.auto_snoozed = result_r.auto_snoozed;
  assign out_chan.dismissed = result_r.dismissed;
  assign out_chan.snoozes_so_far = result_r.snoozes_so_far;

endmodule

[hw/rtl/amas_checker.sv]
// port-level checks for the alarm matcher, bound to the top level
// depends on alarm_match_with_auto_snooze_top_assert.svh
`timescale 1ns / 1ps
`include "alarm_match_with_auto_snooze_top_assert.svh"

module amas_checker (
  input logic        clk,
  input logic        rst_n,
  input logic        out_valid,
  input logic        out_ready,
  input logic        buzzer_on,
  input logic        alarm_ringing,
  input logic [10:0] ringing_minute,
  input logic        auto_snoozed,
  input logic        dismissed,
  input logic [7:0]  snoozes_so_far
);

  // held result stays valid and keeps its shown minute and snooze tally
  `AMAS_ASSERT_NEXT(a_out_hold, clk, rst_n, out_valid && !out_ready, out_valid && $stable(ringing_minute) && $stable(snoozes_so_far))

  // buzzer follows the ringing flag
  `AMAS_ASSERT_IMPLY(a_buzz_eq_ring, clk, rst_n, out_valid, buzzer_on == alarm_ringing)

  // snooze and dismissal stop ringing and never coincide
  `AMAS_ASSERT_IMPLY(a_stop_quiet, clk, rst_n, out_valid && (auto_snoozed || dismissed), !alarm_ringing && !(auto_snoozed && dismissed))

  // tally only moves by one on a snooze
  `AMAS_ASSERT_NEXT(a_tally_step, clk, rst_n, out_valid && out_ready, !out_valid || (snoozes_so_far == $past(snoozes_so_far)) || (auto_snoozed && (snoozes_so_far == $past(snoozes_so_far) + 8'd1)))

endmodule

bind alarm_match_with_auto_snooze_top amas_checker u_amas_checker (
  .clk            (clk),
  .rst_n          (rst_n),
  .out_valid      (out_chan.valid),
  .out_ready      (out_chan.ready),
  .buzzer_on      (out_chan.buzzer_on),
  .alarm_ringing  (out_chan.alarm_ringing),
  .ringing_minute (out_chan.ringing_minute),
  .auto_snoozed   (out_chan.auto_snoozed),
  .dismissed      (out_chan.dismissed),
  .snoozes_so_far (out_chan.snoozes_so_far)
);
